>>> hw/rtl/srsp_pkg.sv
// Shared types and constants for the sensor reply sample parser.
// Holds beat structs, opcode and status codes, and the ring and queue sizes.
// No dependencies.
`default_nettype none

package srsp_pkg;

  // Sample ring geometry
  localparam int RING_DEPTH = 16;
  localparam int RING_AW    = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
  localparam int RING_CW    = $clog2(RING_DEPTH + 1);

  // Output queue geometry (three slots let the input run at full rate while the output takes beats)
  localparam int OQ_DEPTH = 3;
  localparam int OQ_AW    = 2;

  // Reply characters
  localparam logic [7:0] CHAR_PLUS = 8'h2B;
  localparam logic [7:0] CHAR_DOT  = 8'h2E;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;

  // Sample sequence advance per push
  localparam logic [31:0] SEQ_STEP = 32'd2;

  typedef enum logic [1:0] {
    OP_CHAR     = 2'd0,
    OP_LINE_END = 2'd1,
    OP_TIMEOUT  = 2'd2,
    OP_READ     = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    PST_NONE    = 2'd0,
    PST_OK      = 2'd1,
    PST_FRAMING = 2'd2
  } pstat_e;

  typedef struct packed {
    opcode_e     opcode;
    logic [7:0]  char_code;
    logic        measure_ok;
    logic [3:0]  read_index;
  } in_beat_t;

  typedef struct packed {
    logic        cycle_status;
    pstat_e      parse_status;
    logic [31:0] direction;
    logic [31:0] strength_x100;
    logic [4:0]  sample_count;
    logic [31:0] sample_sequence;
    logic [31:0] cycle_sequence;
  } out_beat_t;

  // Parser verdict as seen at the end of a reply line
  typedef struct packed {
    logic        parse_ok;
    logic [31:0] direction;
    logic [31:0] strength_x100;
  } parse_res_t;

endpackage

`default_nettype wire

>>> hw/rtl/srsp_parse.sv
// Character-level reply parser: field splitting and decimal accumulation.
// Presents the sample that a line end would produce; depends on srsp_pkg.
`default_nettype none

module srsp_parse import srsp_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       char_en_i,
  input  wire logic [7:0] char_code_i,
  input  wire logic       clear_i,
  output parse_res_t      res_o
);

  localparam logic [1:0] FIELD_SKIP = 2'd0;
  localparam logic [1:0] FIELD_DIR  = 2'd1;
  localparam logic [1:0] FIELD_STR  = 2'd2;

  logic [1:0]  field_num_q, field_num_d;
  logic        field_empty_q, field_empty_d;
  logic [31:0] dir_acc_q, dir_acc_d;
  logic [31:0] whole_q, whole_d;
  logic [6:0]  frac_q, frac_d;
  logic [1:0]  frac_dig_q, frac_dig_d;
  logic        dot_q, dot_d;
  logic        dir_vld_q, dir_vld_d;
  logic        str_vld_q, str_vld_d;
  logic        bad_q, bad_d;
  logic        done_q, done_d;

  logic        num_char;
  logic [3:0]  dval;
  logic        good;
  logic        closing;
  logic        dir_ok;
  logic        str_ok;
  logic [10:0] frac_scaled;

  // Digits 0x30..0x39 carry their value in the low nibble
  assign num_char = (char_code_i >= CHAR_ZERO) && (char_code_i <= CHAR_NINE);
  assign dval     = char_code_i[3:0];
  assign good     = !field_empty_q && !bad_q;

  // Advance parser state on a character, clear it on clear_i (a line end or timeout)
  always_comb begin
    field_num_d   = field_num_q;
    field_empty_d = field_empty_q;
    dir_acc_d     = dir_acc_q;
    whole_d       = whole_q;
    frac_d        = frac_q;
    frac_dig_d    = frac_dig_q;
    dot_d         = dot_q;
    dir_vld_d     = dir_vld_q;
    str_vld_d     = str_vld_q;
    bad_d         = bad_q;
    done_d        = done_q;
    if (clear_i) begin
      field_num_d   = FIELD_SKIP;
      field_empty_d = 1'b1;
      dir_acc_d     = '0;
      whole_d       = '0;
      frac_d        = '0;
      frac_dig_d    = '0;
      dot_d         = 1'b0;
      dir_vld_d     = 1'b0;
      str_vld_d     = 1'b0;
      bad_d         = 1'b0;
      done_d        = 1'b0;
    end else if (char_en_i && !done_q) begin
      if (char_code_i == CHAR_PLUS) begin
        // Close the current field and open the next one, or finish the line after the strength field
        if (field_num_q == FIELD_DIR) begin
          dir_vld_d   = good;
          field_num_d = FIELD_STR;
        end else if (field_num_q == FIELD_STR) begin
          str_vld_d = good;
          done_d    = 1'b1;
        end else begin
          field_num_d = FIELD_DIR;
        end
        field_empty_d = 1'b1;
        bad_d         = 1'b0;
      end else begin
        field_empty_d = 1'b0;
        if (field_num_q == FIELD_DIR) begin
          if (num_char) begin
            dir_acc_d = 32'(dir_acc_q * 32'd10) + {28'd0, dval};
          end else begin
            bad_d = 1'b1;
          end
        end else if (field_num_q == FIELD_STR) begin
          if (char_code_i == CHAR_DOT) begin
            if (dot_q) begin
              bad_d = 1'b1;
            end
            dot_d = 1'b1;
          end else if (!num_char) begin
            bad_d = 1'b1;
          end else if (!dot_q) begin
            whole_d = 32'(whole_q * 32'd10) + {28'd0, dval};
          end else if (frac_dig_q < 2'd2) begin
            frac_d     = 7'(11'(frac_q) * 11'd10 + {7'd0, dval});
            frac_dig_d = frac_dig_q + 2'd1;
          end
        end
      end
    end
  end

  // Hold parser registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      field_num_q   <= FIELD_SKIP;
      field_empty_q <= 1'b1;
      dir_acc_q     <= '0;
      whole_q       <= '0;
      frac_q        <= '0;
      frac_dig_q    <= '0;
      dot_q         <= 1'b0;
      dir_vld_q     <= 1'b0;
      str_vld_q     <= 1'b0;
      bad_q         <= 1'b0;
      done_q        <= 1'b0;
    end else begin
      field_num_q   <= field_num_d;
      field_empty_q <= field_empty_d;
      dir_acc_q     <= dir_acc_d;
      whole_q       <= whole_d;
      frac_q        <= frac_d;
      frac_dig_q    <= frac_dig_d;
      dot_q         <= dot_d;
      dir_vld_q     <= dir_vld_d;
      str_vld_q     <= str_vld_d;
      bad_q         <= bad_d;
      done_q        <= done_d;
    end
  end

  // Line end closes an open field before the verdict is taken
  assign closing = !done_q && (field_num_q != FIELD_SKIP);
  assign dir_ok  = (closing && field_num_q == FIELD_DIR) ? good : dir_vld_q;
  assign str_ok  = (closing && field_num_q == FIELD_STR) ? good : str_vld_q;

  // Single fraction digit counts tenths
  assign frac_scaled = (frac_dig_q == 2'd1) ? 11'(11'(frac_q) * 11'd10) : {4'd0, frac_q};

  assign res_o.parse_ok      = dir_ok && str_ok;
  assign res_o.direction     = dir_acc_q;
  assign res_o.strength_x100 = 32'(whole_q * 32'd100) + {21'd0, frac_scaled};

endmodule

`default_nettype wire

>>> hw/rtl/sdi_response_sample_parser.sv
// Top level of the sensor reply sample parser: sample ring memory, counters,
// read pipeline and output queue. Depends on srsp_pkg and srsp_parse.
//
// Usage:
//   Input beats carry an opcode. Character beats feed one reply character
//   each and produce no output. A line-end or timeout beat pushes one sample
//   into the 16-entry ring and returns one output beat with status, sample
//   and counters. A read beat returns one output beat with the ring entry.
//   Input beats are taken one per clock while in_stall_o is low; a result
//   passes through the read stage (ring read) and then the output queue,
//   so the sustained rate is one beat per cycle while the output takes beats.
//   in_stall_o comes from registers only: it rises when the three-slot output
//   queue plus the read stage hold three result beats. While out_stall_i is
//   high, input beats keep flowing until three results wait, then the input
//   stalls until the output takes a beat.
//   Reset clears the parser, counters and ring valid bits; ring entries never
//   written read as zero. No clearing pass is needed, so the block accepts
//   beats in the first cycle after reset.
`default_nettype none

module sdi_response_sample_parser import srsp_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_stall_i,
  output out_beat_t      out_data_o
);

  logic               in_acc;
  logic               is_char;
  logic               is_end;
  logic               is_line;
  logic               is_read;
  parse_res_t         pres;

  logic [RING_AW-1:0] ring_head_q, ring_head_d;
  logic [RING_CW-1:0] ring_cnt_q, ring_cnt_d;
  logic [31:0]        push_seq_q, push_seq_d;
  logic [31:0]        poll_seq_q, poll_seq_d;
  logic [RING_DEPTH-1:0] ring_vld_q;

  logic [63:0]        ring_mem [RING_DEPTH];
  logic [63:0]        rd_word_q;
  logic               rd_ok_q;
  logic [RING_AW-1:0] rd_addr;
  logic               rd_in_range;

  logic [31:0]        push_dir;
  logic [31:0]        push_str;
  out_beat_t          s1_beat_d, s1_beat_q;
  logic               s1_valid_q;
  logic               s1_read_q;
  out_beat_t          s1_res;

  out_beat_t          oq_mem [OQ_DEPTH];
  logic [OQ_AW-1:0]   oq_head_q;
  logic [OQ_AW-1:0]   oq_tail_q;
  logic [OQ_AW-1:0]   oq_cnt_q;
  logic               oq_pop;

  // Decode the accepted beat
  assign in_acc  = in_valid_i && !in_stall_o;
  assign is_char = in_data_i.opcode == OP_CHAR;
  assign is_line = in_data_i.opcode == OP_LINE_END;
  assign is_end  = (in_data_i.opcode == OP_LINE_END) || (in_data_i.opcode == OP_TIMEOUT);
  assign is_read = in_data_i.opcode == OP_READ;

  srsp_parse u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .char_en_i   (in_acc && is_char),
    .char_code_i (in_data_i.char_code),
    .clear_i     (in_acc && is_end),
    .res_o       (pres)
  );

  // Sample to push: parsed pair on a clean line, zeros otherwise
  assign push_dir = (is_line && pres.parse_ok) ? pres.direction     : '0;
  assign push_str = (is_line && pres.parse_ok) ? pres.strength_x100 : '0;

  // Advance ring pointer and counters on a push
  always_comb begin
    ring_head_d = ring_head_q;
    ring_cnt_d  = ring_cnt_q;
    push_seq_d  = push_seq_q;
    poll_seq_d  = poll_seq_q;
    if (in_acc && is_end) begin
      ring_head_d = (32'(ring_head_q) == RING_DEPTH - 1) ? '0 : ring_head_q + 1'b1;
      if (32'(ring_cnt_q) < RING_DEPTH) begin
        ring_cnt_d = ring_cnt_q + 1'b1;
      end
      push_seq_d = push_seq_q + SEQ_STEP;
      poll_seq_d = poll_seq_q + 32'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ring_head_q <= '0;
      ring_cnt_q  <= '0;
      push_seq_q  <= '0;
      poll_seq_q  <= '0;
      ring_vld_q  <= '0;
    end else begin
      ring_head_q <= ring_head_d;
      ring_cnt_q  <= ring_cnt_d;
      push_seq_q  <= push_seq_d;
      poll_seq_q  <= poll_seq_d;
      if (in_acc && is_end) begin
        ring_vld_q[ring_head_q] <= 1'b1;
      end
    end
  end

  // Ring memory: write on push, registered read on a read beat
  assign rd_in_range = 32'(in_data_i.read_index) < RING_DEPTH;
  assign rd_addr     = RING_AW'(in_data_i.read_index);

  always_ff @(posedge clk_i) begin
    if (in_acc && is_end) begin
      ring_mem[ring_head_q] <= {push_dir, push_str};
    end
    if (in_acc && is_read) begin
      rd_word_q <= ring_mem[rd_addr];
      rd_ok_q   <= rd_in_range && ring_vld_q[rd_addr];
    end
  end

  // Build the result beat; on a read the registered ring data joins it in the read stage
  always_comb begin
    s1_beat_d.cycle_status    = 1'b0;
    s1_beat_d.parse_status    = PST_NONE;
    s1_beat_d.direction       = '0;
    s1_beat_d.strength_x100   = '0;
    s1_beat_d.sample_count    = 5'(ring_cnt_d);
    s1_beat_d.sample_sequence = push_seq_d;
    s1_beat_d.cycle_sequence  = poll_seq_d;
    if (is_end) begin
      s1_beat_d.direction     = push_dir;
      s1_beat_d.strength_x100 = push_str;
      if (is_line) begin
        s1_beat_d.cycle_status = !in_data_i.measure_ok;
        s1_beat_d.parse_status = pres.parse_ok ? PST_OK : PST_FRAMING;
      end else begin
        s1_beat_d.cycle_status = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s1_read_q  <= 1'b0;
    end else begin
      s1_valid_q <= in_acc && !is_char;
      s1_read_q  <= in_acc && is_read;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_beat_q <= s1_beat_d;
    end
  end

  always_comb begin
    s1_res = s1_beat_q;
    if (s1_read_q) begin
      s1_res.direction     = rd_ok_q ? rd_word_q[63:32] : '0;
      s1_res.strength_x100 = rd_ok_q ? rd_word_q[31:0]  : '0;
    end
  end

  // Output queue: push every finished beat, pop on an unstalled output
  assign oq_pop      = out_valid_o && !out_stall_i;
  assign out_valid_o = oq_cnt_q != '0;
  assign out_data_o  = oq_mem[oq_head_q];
  assign in_stall_o  = ({1'b0, oq_cnt_q} + {{OQ_AW{1'b0}}, s1_valid_q}) >= (OQ_AW + 1)'(OQ_DEPTH);

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      oq_mem[oq_tail_q] <= s1_res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_head_q <= '0;
      oq_tail_q <= '0;
      oq_cnt_q  <= '0;
    end else begin
      if (s1_valid_q) begin
        oq_tail_q <= (32'(oq_tail_q) == OQ_DEPTH - 1) ? '0 : oq_tail_q + 1'b1;
      end
      if (oq_pop) begin
        oq_head_q <= (32'(oq_head_q) == OQ_DEPTH - 1) ? '0 : oq_head_q + 1'b1;
      end
      oq_cnt_q <= oq_cnt_q + OQ_AW'(s1_valid_q) - OQ_AW'(oq_pop);
    end
  end

  // Queue plus read stage never exceed the queue slots
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, oq_cnt_q} + {{OQ_AW{1'b0}}, s1_valid_q}) <= (OQ_AW + 1)'(OQ_DEPTH))
    else $error("output queue overflow");

  // Valid ring entries never exceed the ring depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(ring_cnt_q) <= RING_DEPTH)
    else $error("ring count beyond depth");

  // Each push advances the sample sequence by its step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_end) |=> (push_seq_q == $past(push_seq_q) + SEQ_STEP))
    else $error("sample sequence step wrong");

  // A read beat lands in the read stage on the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && is_read) |=> (s1_valid_q && s1_read_q))
    else $error("read beat lost");

endmodule

`default_nettype wire
